FILE: hdl/cosine_similarity_ring_pairs_assert.svh
// Assertion macros used by the cosine similarity ring-pair controller.
// No dependencies.
`ifndef COSINE_SIMILARITY_RING_PAIRS_ASSERT_SVH
`define COSINE_SIMILARITY_RING_PAIRS_ASSERT_SVH
// implication checked every clock outside reset
`define CSRP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define CSRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hdl/csrp_pkg.sv
// Package for the cosine similarity ring-pair block: constants, command and status types.
// No dependencies.
package csrp_pkg;
  localparam int MAX_DOCS_DEF = 16;
  localparam int MAX_TERMS_DEF = 256;
  localparam int COUNT_BITS_DEF = 16;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int FILE_W = 5;
  localparam int WORD_W = 9;
  localparam int DOC_W = 4;
  localparam int SIM_W = 17;
  localparam int IN_W = 16;
  localparam logic [0:0] REG_FILE_COUNT = 1'b0;
  localparam logic [0:0] REG_WORD_COUNT = 1'b1;

  typedef struct packed {
    logic clr;
    logic acc;
    logic sqrt_start;
    logic div_start;
  } csrp_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
  } csrp_sts_t;
endpackage

FILE: hdl/csrp_datapath.sv
// Datapath: count memory, multiply-accumulate, iterative square roots and divider.
// Depends on csrp_pkg.
module csrp_datapath #(
  parameter int MAX_DOCS = csrp_pkg::MAX_DOCS_DEF,
  parameter int MAX_TERMS = csrp_pkg::MAX_TERMS_DEF,
  parameter int COUNT_BITS = csrp_pkg::COUNT_BITS_DEF,
  parameter int FRACTION_BITS = csrp_pkg::FRACTION_BITS_DEF,
  parameter int ADDR_W = $clog2(MAX_DOCS * MAX_TERMS) + 1
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [COUNT_BITS-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  input  csrp_pkg::csrp_cmd_t cmd,
  output csrp_pkg::csrp_sts_t sts,
  output logic [csrp_pkg::SIM_W-1:0] sim,
  output logic zero
);
  import csrp_pkg::*;
  localparam int DEPTH = MAX_DOCS * MAX_TERMS;
  localparam int PROD_W = 2 * COUNT_BITS;
  localparam int ACC_W = PROD_W + $clog2(MAX_TERMS) + 1;
  localparam int ROOT_W = (ACC_W + 1) / 2;
  localparam int DEN_W = 2 * ROOT_W;
  localparam int SQ_STEPS = ROOT_W;
  localparam int CNT_W = $clog2(SQ_STEPS + FRACTION_BITS + 2) + 1;
  localparam logic [SIM_W-1:0] ONE = SIM_W'(1) << FRACTION_BITS;

  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rd_data;
  logic [ACC_W-1:0] dot, na, nb;
  logic [PROD_W-1:0] p_xy, p_xx, p_yy;
  logic [COUNT_BITS-1:0] xr;
  logic acc_d1, acc_d2, phase_d1;
  logic [DEN_W-1:0] sq_a, sq_b;
  logic [ROOT_W-1:0] ra, rb;
  logic [ACC_W+1:0] rem_a, rem_b;
  logic [CNT_W-1:0] cnt;
  logic sq_busy, dv_busy;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0] r;
  logic [SIM_W-1:0] q;
  logic [ACC_W+1:0] ta, tb, ta_sub, tb_sub;
  logic [DEN_W:0] r2;
  logic phase;
  logic dv_clamp, sq_fin, dv_fin;

  always_ff @(posedge clk) begin
    if (wr_en && wr_addr < ADDR_W'(DEPTH)) mem[wr_addr[$clog2(DEPTH)-1:0]] <= wr_data;
    rd_data <= mem[rd_addr[$clog2(DEPTH)-1:0]];
  end

  // reads alternate row a, row b; phase toggles with each acc command
  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      phase <= 1'b0;
      acc_d1 <= 1'b0;
      acc_d2 <= 1'b0;
      phase_d1 <= 1'b0;
      dot <= '0;
      na <= '0;
      nb <= '0;
    end else begin
      if (cmd.acc) phase <= ~phase;
      acc_d1 <= cmd.acc;
      phase_d1 <= phase;
      acc_d2 <= acc_d1 && phase_d1;
      if (acc_d1 && !phase_d1) xr <= rd_data;
      if (acc_d1 && phase_d1) begin
        p_xy <= PROD_W'(xr) * PROD_W'(rd_data);
        p_xx <= PROD_W'(xr) * PROD_W'(xr);
        p_yy <= PROD_W'(rd_data) * PROD_W'(rd_data);
      end
      if (acc_d2) begin
        dot <= dot + ACC_W'(p_xy);
        na <= na + ACC_W'(p_xx);
        nb <= nb + ACC_W'(p_yy);
      end
    end
  end

  // restoring square root, one result bit per cycle for both norms; also divider clamp and done flags
  always_comb begin
    ta = {rem_a[ACC_W-1:0], sq_a[DEN_W-1 -: 2]};
    tb = {rem_b[ACC_W-1:0], sq_b[DEN_W-1 -: 2]};
    ta_sub = ta - (ACC_W+2)'({ra, 2'b01});
    tb_sub = tb - (ACC_W+2)'({rb, 2'b01});
    r2 = {r[DEN_W-1:0], 1'b0};
    dv_clamp = (DEN_W+1)'(dot) >= {1'b0, den};
    sq_fin = sq_busy && (cnt == CNT_W'(SQ_STEPS - 1));
    dv_fin = dv_busy && ((cnt == '0) ? dv_clamp : (cnt == CNT_W'(FRACTION_BITS)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      dv_busy <= 1'b0;
      sts <= '0;
    end else begin
      sts <= csrp_sts_t'({sq_fin, dv_fin});
      if (cmd.sqrt_start) begin
        sq_busy <= 1'b1;
        sq_a <= DEN_W'(na);
        sq_b <= DEN_W'(nb);
        ra <= '0;
        rb <= '0;
        rem_a <= '0;
        rem_b <= '0;
        cnt <= '0;
      end else if (sq_busy) begin
        sq_a <= sq_a << 2;
        sq_b <= sq_b << 2;
        if (!ta_sub[ACC_W+1]) begin
          rem_a <= ta_sub;
          ra <= {ra[ROOT_W-2:0], 1'b1};
        end else begin
          rem_a <= ta;
          ra <= {ra[ROOT_W-2:0], 1'b0};
        end
        if (!tb_sub[ACC_W+1]) begin
          rem_b <= tb_sub;
          rb <= {rb[ROOT_W-2:0], 1'b1};
        end else begin
          rem_b <= tb;
          rb <= {rb[ROOT_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (sq_fin) sq_busy <= 1'b0;
      end else if (cmd.div_start) begin
        den <= DEN_W'(ra) * DEN_W'(rb);
        dv_busy <= 1'b1;
        cnt <= '0;
        q <= '0;
      end else if (dv_busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == '0) begin
          zero <= (na == '0) || (nb == '0);
          r <= (DEN_W+1)'(dot);
          if (dv_clamp) q <= ONE;
        end else begin
          if (r2 >= {1'b0, den}) begin
            r <= r2 - {1'b0, den};
            q <= {q[SIM_W-2:0], 1'b1};
          end else begin
            r <= r2;
            q <= {q[SIM_W-2:0], 1'b0};
          end
        end
        if (dv_fin) dv_busy <= 1'b0;
      end
    end
  end

  assign sim = zero ? '0 : q;
endmodule

FILE: hdl/csrp_ctrl.sv
// Controller: load addressing, pair sequencing and result handshake.
// Depends on csrp_pkg and the assertion macro header.
`include "cosine_similarity_ring_pairs_assert.svh"
module csrp_ctrl #(
  parameter int MAX_DOCS = csrp_pkg::MAX_DOCS_DEF,
  parameter int MAX_TERMS = csrp_pkg::MAX_TERMS_DEF,
  parameter int ADDR_W = $clog2(MAX_DOCS * MAX_TERMS) + 1
) (
  input  logic clk,
  input  logic rst,
  input  logic [csrp_pkg::FILE_W-1:0] file_count,
  input  logic [csrp_pkg::WORD_W-1:0] word_count,
  input  logic in_acc,
  output logic in_ready,
  output logic wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [ADDR_W-1:0] rd_addr,
  output csrp_pkg::csrp_cmd_t cmd,
  input  csrp_pkg::csrp_sts_t sts,
  output logic out_load,
  output logic [csrp_pkg::DOC_W-1:0] pair_a,
  output logic [csrp_pkg::DOC_W-1:0] pair_b,
  output logic pair_last,
  input  logic out_full
);
  import csrp_pkg::*;
  localparam int RW = $clog2(MAX_DOCS + 1) + 1;
  localparam int CW = $clog2(MAX_TERMS + 1) + 1;

  typedef enum logic [5:0] {
    S_LOAD = 6'b000001, S_READ = 6'b000010, S_DRAIN = 6'b000100,
    S_SQRT = 6'b001000, S_DIV = 6'b010000, S_EMIT = 6'b100000
  } state_t;
  state_t state, state_next;

  logic [RW-1:0] row, files, f, g;
  logic [CW-1:0] col, words, i;
  logic half;
  logic [3:0] drain;

  always_comb begin
    files = (file_count == '0) ? RW'(1) :
            (RW'(file_count) > RW'(MAX_DOCS)) ? RW'(MAX_DOCS) : RW'(file_count);
    words = (word_count == '0) ? CW'(1) :
            (CW'(word_count) > CW'(MAX_TERMS)) ? CW'(MAX_TERMS) : CW'(word_count);
    g = (f + 1'b1 == files) ? '0 : f + 1'b1;
  end

  assign in_ready = (state == S_LOAD);
  assign wr_en = in_acc && row < RW'(MAX_DOCS) && col < CW'(MAX_TERMS);
  assign wr_addr = ADDR_W'(row) * ADDR_W'(MAX_TERMS) + ADDR_W'(col);
  assign rd_addr = ADDR_W'(half ? g : f) * ADDR_W'(MAX_TERMS) + ADDR_W'(i);
  assign pair_a = DOC_W'(f);
  assign pair_b = DOC_W'(g);
  assign pair_last = (f + 1'b1 == files);

  always_comb begin
    state_next = state;
    cmd = '0;
    out_load = 1'b0;
    case (state)
      S_LOAD: if (in_acc && col + 1'b1 >= words && row + 1'b1 >= files) begin
        state_next = S_READ;
        cmd.clr = 1'b1;
      end
      S_READ: begin
        cmd.acc = 1'b1;
        if (half && i + 1'b1 >= words) state_next = S_DRAIN;
      end
      S_DRAIN: if (drain == 4'd3) begin
        state_next = S_SQRT;
        cmd.sqrt_start = 1'b1;
      end
      S_SQRT: if (sts.sqrt_done) begin
        state_next = S_DIV;
        cmd.div_start = 1'b1;
      end
      S_DIV: if (sts.div_done) state_next = S_EMIT;
      S_EMIT: if (!out_full) begin
        out_load = 1'b1;
        if (pair_last) state_next = S_LOAD;
        else begin
          state_next = S_READ;
          cmd.clr = 1'b1;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      row <= '0;
      col <= '0;
      f <= '0;
      i <= '0;
      half <= 1'b0;
      drain <= '0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        if (col + 1'b1 < words) col <= col + 1'b1;
        else begin
          col <= '0;
          row <= (row + 1'b1 < files) ? row + 1'b1 : '0;
        end
      end
      if (state == S_READ) begin
        half <= ~half;
        if (half) i <= i + 1'b1;
      end
      drain <= (state == S_DRAIN) ? drain + 1'b1 : '0;
      if (state == S_LOAD || out_load) i <= '0;
      if (state == S_LOAD) f <= '0;
      else if (out_load) f <= f + 1'b1;
    end
  end

  `CSRP_ASSERT_IMP(a_no_in_busy, clk, rst, in_acc, state == S_LOAD)
  `CSRP_ASSERT_IMP(a_emit_room, clk, rst, out_load, !out_full)
  `CSRP_ASSERT_NEXT(a_last_back, clk, rst, out_load && pair_last, state == S_LOAD)
endmodule

FILE: hdl/cosine_similarity_ring_pairs.sv
// Top level of the cosine similarity ring-pair block: config registers and output register.
// Depends on csrp_pkg, csrp_ctrl, csrp_datapath.
//  channel   dir  handshake        payload
//  input     in   valid / stall    term_value
//  result    out  out_valid/stall  first_doc second_doc similarity zero_norm last_pair
//  config    in   cfg_we           cfg_index cfg_data
// Loading: one count per cycle while stall is low. After the last count each
// pair is read from memory (one read port, two rows interleaved), then drained,
// put through the square roots and the divide, and emitted; the bit-by-bit divide
// is skipped when the quotient clamps.
// Reset is synchronous; stall on the result channel holds the output register
// and pauses the pair sequence.
module cosine_similarity_ring_pairs #(
  parameter int MAX_DOCS = csrp_pkg::MAX_DOCS_DEF,
  parameter int MAX_TERMS = csrp_pkg::MAX_TERMS_DEF,
  parameter int COUNT_BITS = csrp_pkg::COUNT_BITS_DEF,
  parameter int FRACTION_BITS = csrp_pkg::FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [csrp_pkg::WORD_W-1:0] cfg_data,
  input  logic valid,
  output logic stall,
  input  logic [csrp_pkg::IN_W-1:0] term_value,
  output logic out_valid,
  input  logic out_stall,
  output logic [csrp_pkg::DOC_W-1:0] first_doc,
  output logic [csrp_pkg::DOC_W-1:0] second_doc,
  output logic [csrp_pkg::SIM_W-1:0] similarity,
  output logic zero_norm,
  output logic last_pair
);
  import csrp_pkg::*;
  localparam int ADDR_W = $clog2(MAX_DOCS * MAX_TERMS) + 1;

  logic [FILE_W-1:0] file_count;
  logic [WORD_W-1:0] word_count;
  logic in_ready, in_acc, wr_en, out_load, out_full, pair_last, zero;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [DOC_W-1:0] pair_a, pair_b;
  logic [SIM_W-1:0] sim;
  csrp_cmd_t cmd;
  csrp_sts_t sts;

  assign stall = !in_ready;
  assign in_acc = valid && in_ready;
  assign out_full = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_count <= FILE_W'(2);
      word_count <= WORD_W'(256);
    end else if (cfg_we) begin
      if (cfg_index == REG_FILE_COUNT) file_count <= cfg_data[FILE_W-1:0];
      else if (cfg_index == REG_WORD_COUNT) word_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (out_load) begin
      first_doc <= pair_a;
      second_doc <= pair_b;
      similarity <= sim;
      zero_norm <= zero;
      last_pair <= pair_last;
    end
  end

  csrp_ctrl #(.MAX_DOCS(MAX_DOCS), .MAX_TERMS(MAX_TERMS), .ADDR_W(ADDR_W)) u_ctrl (
    .clk(clk), .rst(rst), .file_count(file_count), .word_count(word_count),
    .in_acc(in_acc), .in_ready(in_ready), .wr_en(wr_en), .wr_addr(wr_addr),
    .rd_addr(rd_addr), .cmd(cmd), .sts(sts), .out_load(out_load), .pair_a(pair_a),
    .pair_b(pair_b), .pair_last(pair_last), .out_full(out_full)
  );

  csrp_datapath #(.MAX_DOCS(MAX_DOCS), .MAX_TERMS(MAX_TERMS), .COUNT_BITS(COUNT_BITS),
    .FRACTION_BITS(FRACTION_BITS), .ADDR_W(ADDR_W)) u_dp (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_addr(wr_addr),
    .wr_data(COUNT_BITS'(term_value)), .rd_addr(rd_addr), .cmd(cmd), .sts(sts),
    .sim(sim), .zero(zero)
  );
endmodule

FILE: dv/cosine_similarity_ring_pairs_tb.sv
// Testbench for cosine_similarity_ring_pairs: streams count matrices, predicts each
// neighbouring-row similarity in a local model and checks every result transaction.
// Depends on csrp_pkg and the cosine_similarity_ring_pairs RTL.
module cosine_similarity_ring_pairs_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csrp_pkg::*;

  typedef struct {
    logic [DOC_W-1:0] first_doc;
    logic [DOC_W-1:0] second_doc;
    logic [SIM_W-1:0] similarity;
    logic             zero_norm;
    logic             last_pair;
  } pair_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_FILE_COUNT;
  logic [WORD_W-1:0] cfg_data = '0;
  logic valid = 1'b0;
  logic stall;
  logic [IN_W-1:0] term_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DOC_W-1:0] first_doc, second_doc;
  logic [SIM_W-1:0] similarity;
  logic zero_norm, last_pair;

  logic [IN_W-1:0] count_mirror [MAX_DOCS_DEF][MAX_TERMS_DEF];
  int unsigned load_row_q, load_col_q;
  logic [FILE_W-1:0] files_reg;
  logic [WORD_W-1:0] words_reg;
  pair_result_t pending_pairs [$];
  int src_idle_pct, snk_stall_pct;
  int counts_sent, matrices_done, pairs_checked, zero_pairs, clamped_pairs, errors;

  cosine_similarity_ring_pairs i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .valid(valid), .stall(stall), .term_value(term_value),
    .out_valid(out_valid), .out_stall(out_stall), .first_doc(first_doc),
    .second_doc(second_doc), .similarity(similarity), .zero_norm(zero_norm),
    .last_pair(last_pair)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 21; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic int eff_files();
    if (files_reg == 0) return 1;
    if (files_reg > MAX_DOCS_DEF) return MAX_DOCS_DEF;
    return int'(files_reg);
  endfunction

  function automatic int eff_words();
    if (words_reg == 0) return 1;
    if (words_reg > MAX_TERMS_DEF) return MAX_TERMS_DEF;
    return int'(words_reg);
  endfunction

  // Store one accepted count; on the last count of a matrix queue every pair.
  task automatic absorb_count(input logic [IN_W-1:0] v);
    int files, words, g;
    longint unsigned dot, na, nb, x, y, den, one;
    pair_result_t p;
    files = eff_files();
    words = eff_words();
    one = longint'(1) << FRACTION_BITS_DEF;
    if (load_row_q < MAX_DOCS_DEF && load_col_q < MAX_TERMS_DEF)
      count_mirror[load_row_q][load_col_q] = v;
    if (load_col_q + 1 < words) begin
      load_col_q++;
      return;
    end
    load_col_q = 0;
    if (load_row_q + 1 < files) begin
      load_row_q++;
      return;
    end
    load_row_q = 0;
    for (int f = 0; f < files; f++) begin
      g = (f + 1) % files;
      dot = 0; na = 0; nb = 0;
      for (int i = 0; i < words; i++) begin
        x = 64'(count_mirror[f][i]);
        y = 64'(count_mirror[g][i]);
        dot += x * y;
        na += x * x;
        nb += y * y;
      end
      p.first_doc = DOC_W'(f);
      p.second_doc = DOC_W'(g);
      p.last_pair = (f + 1 == files);
      if (na == 0 || nb == 0) begin
        p.similarity = '0;
        p.zero_norm = 1'b1;
      end else begin
        den = floor_root(na) * floor_root(nb);
        p.zero_norm = 1'b0;
        p.similarity = SIM_W'((dot >= den) ? one : (dot << FRACTION_BITS_DEF) / den);
      end
      pending_pairs.push_back(p);
    end
    matrices_done++;
  endtask

  task automatic send_count(input logic [IN_W-1:0] v);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      valid <= 1'b0;
      @(negedge clk);
    end
    valid <= 1'b1;
    term_value <= v;
    do @(posedge clk); while (stall);
    absorb_count(v);
    counts_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    valid <= 1'b0;
  endtask

  task automatic drain();
    stop_sending();
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [WORD_W-1:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FILE_COUNT) files_reg = d[FILE_W-1:0];
    else words_reg = d;
  endtask

  task automatic set_shape(input int f, input int w);
    drain();
    write_reg(REG_FILE_COUNT, WORD_W'(f));
    write_reg(REG_WORD_COUNT, WORD_W'(w));
  endtask

  // Rows get full-range, small, all-zero or copied-from-above content.
  task automatic send_matrix();
    int start, mode;
    logic [IN_W-1:0] v;
    start = matrices_done;
    mode = 0;
    while (matrices_done == start) begin
      if (load_col_q == 0) mode = $urandom_range(9);
      if (mode < 5) v = IN_W'($urandom_range(16'hffff));
      else if (mode < 7) v = IN_W'($urandom_range(3));
      else if (mode == 7) v = '0;
      else if (load_row_q > 0) v = count_mirror[load_row_q-1][load_col_q];
      else v = IN_W'($urandom_range(16'hffff));
      send_count(v);
    end
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < snk_stall_pct);

  always @(posedge clk) begin
    pair_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected result transaction first_doc=%0d", first_doc);
        errors++;
      end else begin
        e = pending_pairs.pop_front();
        pairs_checked++;
        if (e.zero_norm) zero_pairs++;
        if (e.similarity == (1 << FRACTION_BITS_DEF)) clamped_pairs++;
        if (first_doc !== e.first_doc) begin
          $error("first_doc exp %0d act %0d", e.first_doc, first_doc); errors++;
        end
        if (second_doc !== e.second_doc) begin
          $error("second_doc exp %0d act %0d", e.second_doc, second_doc); errors++;
        end
        if (similarity !== e.similarity) begin
          $error("similarity exp %0d act %0d", e.similarity, similarity); errors++;
        end
        if (zero_norm !== e.zero_norm) begin
          $error("zero_norm exp %0d act %0d", e.zero_norm, zero_norm); errors++;
        end
        if (last_pair !== e.last_pair) begin
          $error("last_pair exp %0d act %0d", e.last_pair, last_pair); errors++;
        end
      end
    end
  end

  task automatic test_directed();
    set_shape(2, 2);
    send_count(16'd0); send_count(16'd0); send_count(16'd5); send_count(16'd7);
    send_count(16'd1); send_count(16'd1); send_count(16'd1); send_count(16'd1);
    set_shape(0, 3);
    repeat (3) send_count(16'hffff);
    set_shape(2, 1);
    send_count(16'hffff); send_count(16'h8000);
  endtask

  task automatic test_register_limits();
    set_shape(31, 0);
    send_matrix();
    set_shape(1, 511);
    send_matrix();
    set_shape(16, 2);
    send_matrix();
  endtask

  task automatic test_mid_matrix_change();
    set_shape(3, 4);
    repeat (6) send_count(IN_W'($urandom_range(16'hffff)));
    drain();
    write_reg(REG_WORD_COUNT, WORD_W'(2));
    send_matrix();
    set_shape(4, 5);
    repeat (9) send_count(IN_W'($urandom_range(16'hffff)));
    drain();
    write_reg(REG_FILE_COUNT, WORD_W'(2));
    send_matrix();
  endtask

  task automatic test_random();
    int target, f, w;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0; snk_stall_pct = 0; end
        1: begin src_idle_pct = 55; snk_stall_pct = 0; end
        2: begin src_idle_pct = 0; snk_stall_pct = 55; end
        default: begin src_idle_pct = 8; snk_stall_pct = 8; end
      endcase
      target = counts_sent + 15;
      while (counts_sent < target) begin
        if ($urandom_range(2) == 0) begin
          f = ($urandom_range(9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 8);
          w = ($urandom_range(9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 10);
          set_shape(f, w);
        end
        send_matrix();
        if ($urandom_range(4) == 0) drain();
      end
    end
  endtask

  initial begin
    files_reg = 2;
    words_reg = 256;
    for (int r = 0; r < MAX_DOCS_DEF; r++)
      for (int c = 0; c < MAX_TERMS_DEF; c++) count_mirror[r][c] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_register_limits();
    test_mid_matrix_change();
    test_random();
    drain();
    repeat (100) @(posedge clk);
    $display("Sent %0d counts in %0d matrices; checked %0d pairs (%0d zero-norm, %0d clamped).",
             counts_sent, matrices_done, pairs_checked, zero_pairs, clamped_pairs);
    $display("Covered register saturation, single row, mid-matrix reshaping and stall phases.");
    if (errors == 0) $display("cosine_similarity_ring_pairs_tb passed");
    else $display("cosine_similarity_ring_pairs_tb failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("cosine_similarity_ring_pairs_tb failed");
    $finish;
  end
endmodule

FILE: cosine_similarity_ring_pairs.f
+incdir+hdl
hdl/csrp_pkg.sv
hdl/csrp_datapath.sv
hdl/csrp_ctrl.sv
hdl/cosine_similarity_ring_pairs.sv
dv/cosine_similarity_ring_pairs_tb.sv
